// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the record exchange sorter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rxs_pkg.sv =====
// Package for the record exchange sorter: sizes, record layout and the
// command bundle passed from the controller to the datapath. No dependencies.
package rxs_pkg;

   localparam int RECORDS = 16;
   localparam int IDX_W   = $clog2(RECORDS);
   localparam int CNT_W   = $clog2(RECORDS + 1);
   localparam int ID_W    = 16;
   localparam int RANK_W  = 8;
   localparam int REC_W   = ID_W + RANK_W;

   // Identifier in the low bits, rank above it.
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [ID_W-1:0]   id;
   } rec_type;

   typedef enum logic {
      WR_SRC_INPUT,
      WR_SRC_HELD
   } wr_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_J,
      ST_LD_J,
      ST_RD_K,
      ST_CMP_K,
      ST_WR_J,
      ST_RD_OUT,
      ST_LD_OUT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic             wr_en;
      wr_src_type       wr_src;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
      logic             load_j;
      logic             cmp_en;
      logic             load_out;
      logic             out_last;
   } cmd_type;

endpackage

// ===== rtl/record_exchange_sorter.sv =====
// Record exchange sorter, top level: joins the controller and the datapath
// and maps the stream ports. Uses rxs_pkg, rxs_ctrl and rxs_dpath.
//
// The block collects records (a 16-bit identifier and an 8-bit rank) into a
// store of rxs_pkg::RECORDS entries. After every stored word it runs a full
// exchange pass over the filled prefix of n records: for each j and each k
// it swaps the two records when rank j is strictly below rank k, which leaves
// the prefix ascending by rank. When a word arrives with tlast set, or fills
// the store, the set is emitted in ascending rank order with tlast on the
// final word, and the store is emptied for the next set. One word is taken at
// a time: req_tready is low until the exchange pass is through. The pass
// reads record j, then reads and compares each other record k, and writes
// record j back, through the single read and write port of the record store.
// Each word is emitted by a read, a load of the result register and a send
// that waits for the consumer. No clearing pass follows reset.
module record_exchange_sorter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // officer_id [15:0], rank_key [23:16]
   input  logic        req_tlast,   // last_record
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sorted_id [15:0], sorted_rank [23:16]
   output logic        rsp_tlast    // last_out
);

   rxs_pkg::cmd_type cmd;
   rxs_pkg::rec_type in_rec;
   rxs_pkg::rec_type out_rec;

   // The record layout matches the word layout: identifier low, rank high.
   assign in_rec    = rxs_pkg::rec_type'(req_tdata);
   assign rsp_tdata = out_rec;

   rxs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rxs_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .in_rec   (in_rec),
      .out_rec  (out_rec),
      .out_last (rsp_tlast)
   );

endmodule

// ===== rtl/rxs_dpath.sv =====
// Datapath of the record exchange sorter: the record store, the held record
// of the outer loop, the rank comparator and the result register. Uses rxs_pkg.
module rxs_dpath (
   input  logic             clock,
   input  rxs_pkg::cmd_type cmd,
   input  rxs_pkg::rec_type in_rec,
   output rxs_pkg::rec_type out_rec,
   output logic             out_last
);

   rxs_pkg::rec_type store_mem [rxs_pkg::RECORDS];
   rxs_pkg::rec_type rd_data_ff;
   rxs_pkg::rec_type rec_j_ff;
   rxs_pkg::rec_type rec_j_in;
   rxs_pkg::rec_type out_rec_ff;
   rxs_pkg::rec_type out_rec_in;
   logic             out_last_ff;
   logic             out_last_in;
   rxs_pkg::rec_type wr_data;
   logic             swap;
   logic             wr_en;

   // The held record moves down when its rank is strictly below the probed one.
   assign swap  = cmd.cmp_en && (rec_j_ff.rank < rd_data_ff.rank);
   assign wr_en = cmd.wr_en || swap;

   always_comb begin
      case (cmd.wr_src)
         rxs_pkg::WR_SRC_INPUT: wr_data = in_rec;
         rxs_pkg::WR_SRC_HELD:  wr_data = rec_j_ff;
         default:               wr_data = rec_j_ff;
      endcase
   end

   always_comb begin
      rec_j_in = rec_j_ff;
      if (cmd.load_j || swap) begin
         rec_j_in = rd_data_ff;
      end
      out_rec_in  = out_rec_ff;
      out_last_in = out_last_ff;
      if (cmd.load_out) begin
         out_rec_in  = rd_data_ff;
         out_last_in = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[cmd.wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      rec_j_ff    <= rec_j_in;
      out_rec_ff  <= out_rec_in;
      out_last_ff <= out_last_in;
   end

   assign out_rec  = out_rec_ff;
   assign out_last = out_last_ff;

endmodule

// ===== rtl/rxs_ctrl.sv =====
// Controller of the record exchange sorter: load, exchange pass and emission
// sequencing. Uses rxs_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module rxs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output rxs_pkg::cmd_type cmd
);

   rxs_pkg::state_type        state_ff, state_in;
   logic [rxs_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [rxs_pkg::IDX_W-1:0] j_ff, j_in;
   logic [rxs_pkg::IDX_W-1:0] k_ff, k_in;
   logic [rxs_pkg::IDX_W-1:0] i_ff, i_in;
   logic                      last_ff, last_in;
   logic [rxs_pkg::CNT_W-1:0] fill_next;
   logic [rxs_pkg::IDX_W-1:0] last_idx;

   assign fill_next = fill_ff + rxs_pkg::CNT_W'(1);
   assign last_idx  = rxs_pkg::IDX_W'(fill_ff - rxs_pkg::CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rxs_pkg::ST_IDLE;
         fill_ff  <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      last_in    = last_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      cmd.wr_src = rxs_pkg::WR_SRC_HELD;

      case (state_ff)
         rxs_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.wr_src  = rxs_pkg::WR_SRC_INPUT;
            cmd.wr_addr = rxs_pkg::IDX_W'(fill_ff);
            if (req_tvalid) begin
               cmd.wr_en = 1'b1;
               fill_in   = fill_next;
               // A record that fills the store closes the set.
               last_in   = req_tlast ||
                           (fill_next == rxs_pkg::CNT_W'(rxs_pkg::RECORDS));
               j_in      = '0;
               state_in  = rxs_pkg::ST_RD_J;
            end
         end
         rxs_pkg::ST_RD_J: begin
            cmd.rd_addr = j_ff;
            state_in    = rxs_pkg::ST_LD_J;
         end
         rxs_pkg::ST_LD_J: begin
            cmd.load_j = 1'b1;
            k_in       = '0;
            state_in   = rxs_pkg::ST_RD_K;
         end
         rxs_pkg::ST_RD_K: begin
            cmd.rd_addr = k_ff;
            // Comparing the held record with itself never swaps.
            if (k_ff == j_ff) begin
               if (k_ff == last_idx) begin
                  state_in = rxs_pkg::ST_WR_J;
               end else begin
                  k_in = k_ff + rxs_pkg::IDX_W'(1);
               end
            end else begin
               state_in = rxs_pkg::ST_CMP_K;
            end
         end
         rxs_pkg::ST_CMP_K: begin
            cmd.cmp_en  = 1'b1;
            cmd.wr_addr = k_ff;
            if (k_ff == last_idx) begin
               state_in = rxs_pkg::ST_WR_J;
            end else begin
               k_in     = k_ff + rxs_pkg::IDX_W'(1);
               state_in = rxs_pkg::ST_RD_K;
            end
         end
         rxs_pkg::ST_WR_J: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff;
            if (j_ff == last_idx) begin
               i_in     = '0;
               state_in = last_ff ? rxs_pkg::ST_RD_OUT : rxs_pkg::ST_IDLE;
            end else begin
               j_in     = j_ff + rxs_pkg::IDX_W'(1);
               state_in = rxs_pkg::ST_RD_J;
            end
         end
         rxs_pkg::ST_RD_OUT: begin
            cmd.rd_addr = i_ff;
            state_in    = rxs_pkg::ST_LD_OUT;
         end
         rxs_pkg::ST_LD_OUT: begin
            cmd.load_out = 1'b1;
            cmd.out_last = (i_ff == last_idx);
            state_in     = rxs_pkg::ST_SEND;
         end
         rxs_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (i_ff == last_idx) begin
                  fill_in  = '0;
                  state_in = rxs_pkg::ST_IDLE;
               end else begin
                  i_in     = i_ff + rxs_pkg::IDX_W'(1);
                  state_in = rxs_pkg::ST_RD_OUT;
               end
            end
         end
         default: begin
            state_in = rxs_pkg::ST_IDLE;
         end
      endcase
   end

   `ASSERT_ALWAYS(a_one_side, !(req_tready && rsp_tvalid), "load and emission overlap")
   `ASSERT_ALWAYS(a_fill_range, fill_ff <= rxs_pkg::CNT_W'(rxs_pkg::RECORDS), "fill overflow")
   `ASSERT_ALWAYS(a_no_self_cmp, (state_ff != rxs_pkg::ST_CMP_K) || (k_ff != j_ff),
      "held record compared with itself")
   `ASSERT_NEXT(a_set_done, rsp_tvalid && rsp_tready && (i_ff == last_idx),
      (fill_ff == '0) && (state_ff == rxs_pkg::ST_IDLE), "store not emptied after set")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for record_exchange_sorter: drives record sets with
// random gaps and stalls and predicts every sorted word with its own model.
// Depends on rxs_pkg and the RTL of record_exchange_sorter only.
module testbench;
   import rxs_pkg::*;

   localparam int PERIOD       = 8;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int ITEM_TARGET  = 250;
   localparam int SETTLE       = 64;

   // Ranks of the directed full set: both extremes, repeats and a spread.
   localparam logic [7:0] FULL_SET_RANKS [RECORDS] = '{
      8'h80, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h01, 8'hFE,
      8'h80, 8'h40, 8'h00, 8'hC3, 8'hFF, 8'h3C, 8'h80, 8'h01};

   typedef struct packed {
      rec_type rec;
      logic    last;
   } sorted_word_type;

   // Holds a copy of the record store and the sorted words still to come out.
   class sort_scoreboard;
      rec_type         held [RECORDS];
      int              fill;
      sorted_word_type pending_sorted [$];
      int              failures;

      // Stores the record, runs the exchange pass over the filled prefix and,
      // at the end of a set, queues the whole prefix in store order.
      function void absorb_record(rec_type rec, logic last);
         rec_type         swap_rec;
         sorted_word_type word;
         if (fill >= RECORDS) begin
            fill = 0;
         end
         held[fill] = rec;
         fill++;
         for (int j = 0; j < fill; j++) begin
            for (int k = 0; k < fill; k++) begin
               if (held[j].rank < held[k].rank) begin
                  swap_rec = held[j];
                  held[j]  = held[k];
                  held[k]  = swap_rec;
               end
            end
         end
         if (last || fill == RECORDS) begin
            for (int i = 0; i < fill; i++) begin
               word.rec  = held[i];
               word.last = (i == fill - 1);
               pending_sorted.push_back(word);
            end
            fill = 0;
         end
      endfunction

      function void check_sorted_word(rec_type rec, logic last);
         sorted_word_type want;
         if (pending_sorted.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Unexpected word at %0t: id %h rank %h last %b",
                        $time, rec.id, rec.rank, last);
            end
         end else begin
            want = pending_sorted.pop_front();
            if (want.rec.id !== rec.id || want.rec.rank !== rec.rank
                || want.last !== last) begin
               failures++;
               if (failures <= 10) begin
                  $write("Mismatch at %0t: expected id %h rank %h last %b,",
                         $time, want.rec.id, want.rec.rank, want.last);
                  $display(" got id %h rank %h last %b", rec.id, rec.rank, last);
               end
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   // While set, neither side inserts idle cycles.
   logic        no_idle    = 1'b0;

   sort_scoreboard sb = new();

   record_exchange_sorter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #(PERIOD / 2) clock = 1'b1;
      #(PERIOD / 2) clock = 1'b0;
   end

   // The consumer stalls now and then, except during the quiet stretch.
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 7);
   end

   // Every word taken on the result side is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_sorted_word(rec_type'(rsp_tdata), rsp_tlast);
      end
   end

   // Offers one record, with an occasional idle gap first, and waits until
   // the block takes it. The valid is left high for the next call to decide.
   task automatic send_record(input rec_type rec, input logic last);
      while (!no_idle && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rec;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.absorb_record(rec, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_sorted.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int         sent;
      int         set_len;
      bit         close_full;
      bit         dup_ranks;
      logic [7:0] rank_base;
      rec_type    rec;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A set of one record with every bit set.
      send_record('{rank: 8'hFF, id: 16'hFFFF}, 1'b1);

      // Sixteen records without tlast: the full store closes the set.
      for (int i = 0; i < RECORDS; i++) begin
         rec.rank = FULL_SET_RANKS[i];
         rec.id   = 16'hA500 + 16'(i);
         send_record(rec, 1'b0);
      end

      // Equal ranks, so the order left by the swaps is visible.
      for (int i = 0; i < 3; i++) begin
         send_record('{rank: 8'h55, id: 16'(i)}, i == 2);
      end

      // Two records arriving in descending order, lowest ranks.
      send_record('{rank: 8'h01, id: 16'h1234}, 1'b0);
      send_record('{rank: 8'h00, id: 16'h5678}, 1'b1);

      // Let everything come out before the random part starts.
      wait_drained();

      sent = 0;
      while (sent < ITEM_TARGET) begin
         no_idle <= (sent >= 100 && sent < 160);
         if ($urandom_range(0, 9) == 0) begin
            set_len    = RECORDS;
            close_full = $urandom_range(0, 1);
         end else begin
            set_len    = $urandom_range(1, RECORDS - 1);
            close_full = 1'b1;
         end
         // A third of the sets crowd their ranks into a narrow window.
         dup_ranks = ($urandom_range(0, 2) == 0);
         rank_base = 8'($urandom_range(0, 255));
         for (int i = 0; i < set_len; i++) begin
            rec.id   = 16'($urandom_range(0, 65535));
            rec.rank = dup_ranks ? 8'(rank_base + 8'($urandom_range(0, 2)))
                                 : 8'($urandom_range(0, 255));
            send_record(rec, (i == set_len - 1) && close_full);
         end
         sent += set_len;
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (sb.failures == 0 && sb.pending_sorted.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(LIMIT_CYCLES * PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rxs_pkg.sv
rtl/rxs_dpath.sv
rtl/rxs_ctrl.sv
rtl/record_exchange_sorter.sv
dv/testbench.sv
